>>> rtl/core/assert_macros.svh
// assertion macros shared by the radix digit converter rtl
// every user needs clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock while out of reset
`define RDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition on one clock implies another on the next clock
`define RDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

>>> rtl/core/rdc_pkg.sv
// shared constants, types and tables for the radix digit converter
// no dependencies
package rdc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int RADIX_W     = 5;
  localparam int POS_W       = 5;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 4;
  localparam int LO_W        = 6;  // low-bit window that holds any partial remainder
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CHAR_W + POS_W + 7) / 8) * 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  // floor(2^VALUE_WIDTH / base), estimate is exact or one low
  localparam logic [VALUE_WIDTH:0] RECIP_ONE = {1'b1, {VALUE_WIDTH{1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] RECIP_TBL [17] = '{
    '0, '0,
    VALUE_WIDTH'(RECIP_ONE / 2),  VALUE_WIDTH'(RECIP_ONE / 3),
    VALUE_WIDTH'(RECIP_ONE / 4),  VALUE_WIDTH'(RECIP_ONE / 5),
    VALUE_WIDTH'(RECIP_ONE / 6),  VALUE_WIDTH'(RECIP_ONE / 7),
    VALUE_WIDTH'(RECIP_ONE / 8),  VALUE_WIDTH'(RECIP_ONE / 9),
    VALUE_WIDTH'(RECIP_ONE / 10), VALUE_WIDTH'(RECIP_ONE / 11),
    VALUE_WIDTH'(RECIP_ONE / 12), VALUE_WIDTH'(RECIP_ONE / 13),
    VALUE_WIDTH'(RECIP_ONE / 14), VALUE_WIDTH'(RECIP_ONE / 15),
    VALUE_WIDTH'(RECIP_ONE / 16)
  };

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX
  } rdc_state_t;

  typedef struct packed {
    logic               load;
    logic               mul;
    logic [RADIX_W-1:0] base;
  } rdc_div_req_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] quot;
    logic [RADIX_W-1:0]     rem;
  } rdc_div_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
    logic               last;
  } rdc_emit_t;

endpackage

>>> rtl/core/rdc_div_unit.sv
// shared divide-by-base unit: reciprocal multiply, then remainder fix-up
// depends on rdc_pkg and assert_macros.svh
`include "assert_macros.svh"

module rdc_div_unit
  import rdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  rdc_div_req_t           req,
  input  logic [VALUE_WIDTH-1:0] dividend,
  output rdc_div_rsp_t           rsp
);

  logic [VALUE_WIDTH-1:0]      recip_r;
  logic [RADIX_W-1:0]          base_r;
  logic [PROD_W-1:0]           prod_r;

  logic [VALUE_WIDTH-1:0]      q_est;
  logic [VALUE_WIDTH+LO_W-1:0] q_ext;
  logic [VALUE_WIDTH+LO_W-1:0] v_ext;
  logic [LO_W-1:0]             base_lo;
  logic [LO_W-1:0]             qd_lo;
  logic [LO_W-1:0]             r_est;
  logic                        r_ge;

  always_ff @(posedge clk) begin
    if (req.load) begin
      recip_r <= RECIP_TBL[req.base];
      base_r  <= req.base;
    end
    if (req.mul) begin
      prod_r <= PROD_W'(dividend) * PROD_W'(recip_r);
    end
  end

  // true remainder is below twice the base, so six low bits settle it
  always_comb begin
    q_est   = prod_r[PROD_W-1 -: VALUE_WIDTH];
    q_ext   = {{LO_W{1'b0}}, q_est};
    v_ext   = {{LO_W{1'b0}}, dividend};
    base_lo = LO_W'(base_r);
    qd_lo   = q_ext[LO_W-1:0] * base_lo;
    r_est   = v_ext[LO_W-1:0] - qd_lo;
    r_ge    = (r_est >= base_lo);
    rsp.rem  = r_ge ? RADIX_W'(r_est - base_lo) : RADIX_W'(r_est);
    rsp.quot = q_est + VALUE_WIDTH'(r_ge);
  end

  `RDC_ASSERT(a_rem_lt_base, $past(req.mul) |-> (rsp.rem < base_r), "remainder not below base")
  `RDC_ASSERT(a_quot_shrinks, $past(req.mul) && (dividend != '0) |-> (rsp.quot < dividend), "quotient not below dividend")

endmodule

>>> rtl/core/rdc_ctrl.sv
// sequencer: takes a value, steps the divide unit once per digit, emits digits
// depends on rdc_pkg and assert_macros.svh
`include "assert_macros.svh"

module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   in_ready,
  input  logic [RADIX_W-1:0]     base,
  input  logic                   out_free,
  output rdc_div_req_t           div_req,
  input  rdc_div_rsp_t           div_rsp,
  output logic [VALUE_WIDTH-1:0] dividend,
  output rdc_emit_t              emit
);

  rdc_state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] v_r, v_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    pos_r <= pos_nxt;
  end

  assign dividend = v_r;

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    pos_nxt   = pos_r;
    in_ready  = 1'b0;
    div_req   = '0;
    emit      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          v_nxt        = in_value;
          pos_nxt      = '0;
          div_req.load = 1'b1;
          div_req.base = base;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        div_req.mul = 1'b1;
        state_nxt   = ST_FIX;
      end
      ST_FIX: begin
        // hold the product until the output register can take the digit
        if (out_free) begin
          emit.valid = 1'b1;
          emit.digit = div_rsp.rem[DIGIT_W-1:0];
          emit.pos   = pos_r;
          emit.last  = (div_rsp.quot == '0);
          v_nxt      = div_rsp.quot;
          pos_nxt    = pos_r + POS_W'(1);
          state_nxt  = emit.last ? ST_IDLE : ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `RDC_ASSERT_NEXT(a_last_ends_item, emit.valid && emit.last, state_r == ST_IDLE, "no return to idle after last digit")
  `RDC_ASSERT_NEXT(a_digit_spacing, emit.valid && !emit.last, !emit.valid, "digits closer than two cycles")

endmodule

>>> rtl/core/radix_digit_converter.sv
// radix digit converter top level: radix register, sequencer, divide unit, output register
// depends on rdc_pkg, rdc_div_unit, rdc_ctrl
//
// Usage:
//   Input stream: in_tdata carries one unsigned value per transfer. The block
//   answers with one output transfer per digit in the base held by the radix
//   register, least significant digit first; out_tlast marks the most
//   significant digit. A zero value gives a single '0'.
//   Configuration: cfg_wr_en writes cfg_wr_data into the radix register.
//   Values below 2 act as base 2, values above 16 act as base 16. Write it
//   only while no conversion is in flight.
//   Timing: in_tready is high only while the block is idle, so a new value
//   is taken only after the last digit of the current one has been handed to
//   the output register. Each digit passes through a reciprocal multiply
//   state, whose product the divide unit registers, and then a remainder
//   correction state that hands the digit to the output register.
//   Stall: while out_tready is low the held digit stays put and the sequencer
//   waits with its next digit, handing it over in the cycle the held one leaves.
//   Reset: rst_n low sets the radix to 10 and drops out_tvalid; any
//   conversion in progress is abandoned.
module radix_digit_converter
  import rdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [6:0] digit_char, [11:7] digit_position
  output logic                   out_tlast,
  input  logic                   cfg_wr_en,
  input  logic [RADIX_W-1:0]     cfg_wr_data
);

  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     base_eff;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r;
  logic [POS_W-1:0]       out_pos_r;
  logic                   out_last_r;
  logic                   out_free;

  rdc_div_req_t           div_req;
  rdc_div_rsp_t           div_rsp;
  logic [VALUE_WIDTH-1:0] dividend;
  rdc_emit_t              emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      base_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base_eff = RADIX_MAX;
    end else begin
      base_eff = radix_r;
    end
  end

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_value (in_tdata[VALUE_WIDTH-1:0]),
    .in_ready (in_tready),
    .base     (base_eff),
    .out_free (out_free),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .dividend (dividend),
    .emit     (emit)
  );

  rdc_div_unit u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (dividend),
    .rsp      (div_rsp)
  );

  // output register frees up in the same cycle its transfer completes
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_char_r <= DIGIT_CHARS[emit.digit];
      out_pos_r  <= emit.pos;
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_pos_r, out_char_r});
  assign out_tlast  = out_last_r;

endmodule

>>> dv/tb_top.sv
// testbench for radix_digit_converter: streams values in and checks every digit transfer
// against an in-bench digit predictor; depends on rdc_pkg and the radix_digit_converter rtl
`timescale 1ns / 1ps

module tb_top;
  import rdc_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 70;    // extra idle cycles after the last test, before the final check
  localparam int PHASE_ITEMS  = 45;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
  } digit_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [31:0] value
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [6:0] digit_char, [11:7] digit_position
  logic                   out_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0]     cfg_wr_data = '0;

  logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
  digit_t             digit_q[$];
  bit                 src_idle_on = 1'b1;
  bit                 sink_idle_on = 1'b1;
  int unsigned        mismatch_cnt = 0;
  int unsigned        values_sent = 0;
  int unsigned        digits_seen = 0;
  int unsigned        radix_writes = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        stall_left = 0;

  radix_digit_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // register values outside two..sixteen clamp to the nearest legal base
  function automatic int unsigned active_base();
    if (radix_shadow < RADIX_MIN) return RADIX_MIN;
    if (radix_shadow > RADIX_MAX) return RADIX_MAX;
    return radix_shadow;
  endfunction

  // queue the digit string of one value, least significant digit first
  function automatic void predict_digits(input logic [31:0] value);
    int unsigned base;
    int unsigned rem;
    logic [31:0] rest;
    digit_t      d;
    int unsigned idx;
    base = active_base();
    rest = value;
    idx  = 0;
    do begin
      rem    = rest % base;
      rest   = rest / base;
      d.ch   = (rem < 10) ? CHAR_W'(8'h30 + rem) : CHAR_W'(8'h61 + rem - 10);
      d.pos  = POS_W'(idx);
      d.last = (rest == 0);
      digit_q.push_back(d);
      idx++;
    end while (rest != 0);
  endfunction

  // mix of full-width, short and digit-boundary values for the current base
  function automatic logic [31:0] pick_value();
    longint unsigned p;
    int unsigned     base;
    int unsigned     steps;
    base = active_base();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $urandom >> $urandom_range(0, 31);
      3:    return $urandom_range(0, 2 * base);
      default: begin
        // base^k or base^k - 1, where the digit count changes
        steps = $urandom_range(1, 32);
        p = 1;
        while (steps > 0 && p * base <= 64'hFFFF_FFFF) begin
          p = p * base;
          steps--;
        end
        return $urandom_range(0, 1) ? 32'(p) : 32'(p - 1);
      end
    endcase
  endfunction

  task automatic send_value(input logic [31:0] value);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    predict_digits(value);
    values_sent++;
  endtask

  // hold the sender until every queued digit has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (digit_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    radix_shadow = r;
    radix_writes++;
  endtask

  task automatic test_reset_base();
    send_value(32'd0);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'd1_000_000_000);
    send_value(32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_base_clamping();
    logic [RADIX_W-1:0] edge_radix[6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
    foreach (edge_radix[i]) begin
      write_radix(edge_radix[i]);
      send_value(32'd0);
      send_value(32'hFFFF_FFFF);
    end
    // every hex letter shows up here
    send_value(32'hFEDC_BA98);
    send_value(32'h0123_ABCD);
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [RADIX_W-1:0] r;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)      r = RADIX_MIN;
      else if (ph == 7) r = RADIX_MAX;
      else if ($urandom_range(0, 3) == 0) r = $urandom_range(0, 31);
      else r = $urandom_range(2, 16);
      if (ph == 7) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      write_radix(r);
      repeat (PHASE_ITEMS) send_value(pick_value());
    end
    wait_drained();
  endtask

  // result side backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      digits_seen++;
      if (digit_q.size() == 0) begin
        $display("%0t: unexpected digit transfer char=%h pos=%0d last=%b", $time,
                 out_tdata[6:0], out_tdata[11:7], out_tlast);
        mismatch_cnt++;
      end else begin
        want = digit_q.pop_front();
        if (out_tdata[6:0] !== want.ch) begin
          $display("%0t: digit_char expected %h actual %h", $time, want.ch, out_tdata[6:0]);
          mismatch_cnt++;
        end
        if (out_tdata[11:7] !== want.pos) begin
          $display("%0t: digit_position expected %0d actual %0d", $time, want.pos,
                   out_tdata[11:7]);
          mismatch_cnt++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last_digit expected %b actual %b", $time, want.last, out_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d digits outstanding", $time,
                 quiet_cycles, digit_q.size());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_base();
    test_base_clamping();
    test_random_phases();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d values, %0d digit transfers, %0d radix writes", values_sent,
             digits_seen, radix_writes);
    $display("bases clamped from both ends, zero and all-ones values, stalls on both sides");
    if (mismatch_cnt == 0 && digit_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
